// ----- rtl/core/xfsd_pkg.sv -----
package xfsd_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int VALUE_W         = 64;
  localparam int CFG_W           = 24;
  localparam int FIELD_W         = 6;
  localparam int LEFT_W          = 7;
  localparam int BYTE_W          = 8;
  localparam int MAX_RESULTS     = 64;

  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] data_byte;
    logic              block_start;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value_bits;
    logic               block_done;
    logic               malformed;
    logic               last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bits_done;
    logic slot_ok;
  } sts_t;

endpackage

// ----- rtl/core/xfsd_ctrl.sv -----
module xfsd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  xfsd_pkg::sts_t sts,
  output xfsd_pkg::cmd_t cmd
);
  import xfsd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:  cmd.load  = in_valid;
      S_RUN:   cmd.step  = !sts.bits_done && sts.slot_ok;
      S_FLUSH: cmd.flush = sts.slot_ok;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_RUN;
            in_ready_r <= 1'b0;
          end
        end
        S_RUN: begin
          if (sts.bits_done) begin
            state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (sts.slot_ok) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/xfsd_dp.sv -----
module xfsd_dp #(
  parameter int COUNT_WIDTH = xfsd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [xfsd_pkg::CFG_W-1:0]  cfg_wr_data,
  input  xfsd_pkg::in_t               in_data,
  input  xfsd_pkg::cmd_t              cmd,
  output xfsd_pkg::sts_t              sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output xfsd_pkg::out_t              out_data
);
  import xfsd_pkg::*;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_CTRL1,
    PH_CTRL2,
    PH_LEAD,
    PH_LEN,
    PH_PAY,
    PH_PAY_BAD,
    PH_DONE
  } phase_t;

  localparam int RCNT_W = $clog2(MAX_RESULTS + 1);
  localparam int BCNT_W = $clog2(BYTE_W + 1);

  logic [COUNT_WIDTH-1:0]        vcount_r;
  logic [COUNT_WIDTH+CFG_W-1:0]  cfg_ext;

  logic [VALUE_W-1:0]     prev_r, prev_nxt;
  logic [VALUE_W-1:0]     acc_r, acc_nxt, acc_sh;
  logic [FIELD_W-1:0]     wlead_r, wlead_nxt;
  logic [FIELD_W-1:0]     wtrail_r, wtrail_nxt;
  logic [FIELD_W-1:0]     plead_r, plead_nxt;
  logic [LEFT_W-1:0]      left_r, left_nxt, left_dec;
  logic [COUNT_WIDTH-1:0] vdone_r, vdone_inc;
  phase_t                 phase_r, phase_nxt;

  logic [BYTE_W-1:0]      shreg_r;
  logic                   drain_r;
  logic [BCNT_W-1:0]      bcnt_r;
  logic [RCNT_W-1:0]      rcnt_r;

  out_t pend_r;
  logic pend_v_r;
  out_t out_r;
  logic out_v_r;

  logic               bit_in;
  logic               finished;
  logic               emit;
  logic               emit_bad;
  logic               emit_done;
  logic               out_free;
  logic               out_load;
  logic [LEFT_W-1:0]  len7;
  logic [LEFT_W-1:0]  lsum;
  logic [FIELD_W-1:0] sh;
  logic               do_step;

  assign cfg_ext   = {{COUNT_WIDTH{1'b0}}, cfg_wr_data};
  assign bit_in    = shreg_r[BYTE_W-1];
  assign finished  = (phase_r == PH_DONE) || (vdone_r >= vcount_r);
  assign vdone_inc = vdone_r + 1'b1;
  assign emit_done = vdone_inc >= vcount_r;
  assign out_free  = !out_v_r || out_ready;
  assign do_step   = cmd.step && !finished;
  assign out_load  = pend_v_r && ((do_step && emit) || cmd.flush);

  assign sts.slot_ok   = !pend_v_r || out_free;
  assign sts.bits_done = drain_r ? (finished || rcnt_r == RCNT_W'(MAX_RESULTS))
                                 : (bcnt_r == BCNT_W'(BYTE_W));

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign acc_sh   = {acc_r[VALUE_W-2:0], bit_in};
  assign left_dec = (left_r != '0) ? left_r - 1'b1 : '0;
  assign len7     = (acc_sh[FIELD_W-1:0] == '0) ? LEFT_W'(VALUE_W)
                                                : {1'b0, acc_sh[FIELD_W-1:0]};
  assign lsum     = {1'b0, plead_r} + len7;
  assign sh       = (phase_r == PH_PAY_BAD) ? '0 : wtrail_r;

  always_comb begin
    prev_nxt   = prev_r;
    acc_nxt    = acc_r;
    wlead_nxt  = wlead_r;
    wtrail_nxt = wtrail_r;
    plead_nxt  = plead_r;
    left_nxt   = left_r;
    phase_nxt  = phase_r;
    emit       = 1'b0;
    emit_bad   = 1'b0;
    unique case (phase_r)
      PH_FIRST: begin
        if (left_r == '0) begin
          acc_nxt  = {{(VALUE_W-1){1'b0}}, bit_in};
          left_nxt = LEFT_W'(VALUE_W - 1);
        end else begin
          acc_nxt  = acc_sh;
          left_nxt = left_r - 1'b1;
        end
        if (left_nxt == '0) begin
          prev_nxt = acc_nxt;
          acc_nxt  = '0;
          emit     = 1'b1;
        end
      end
      PH_CTRL1: begin
        if (!bit_in) begin
          emit = 1'b1;
        end else begin
          phase_nxt = PH_CTRL2;
        end
      end
      PH_CTRL2: begin
        acc_nxt = '0;
        if (!bit_in) begin
          left_nxt  = LEFT_W'(FIELD_W);
          phase_nxt = PH_LEAD;
        end else begin
          left_nxt  = LEFT_W'(VALUE_W) - {1'b0, wlead_r} - {1'b0, wtrail_r};
          phase_nxt = PH_PAY;
        end
      end
      PH_LEAD: begin
        acc_nxt  = acc_sh;
        left_nxt = left_r - 1'b1;
        if (left_nxt == '0) begin
          plead_nxt = acc_sh[FIELD_W-1:0];
          acc_nxt   = '0;
          left_nxt  = LEFT_W'(FIELD_W);
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        acc_nxt  = acc_sh;
        left_nxt = left_r - 1'b1;
        if (left_nxt == '0) begin
          wlead_nxt = plead_r;
          acc_nxt   = '0;
          left_nxt  = len7;
          if (lsum > LEFT_W'(VALUE_W)) begin
            wtrail_nxt = '0;
            phase_nxt  = PH_PAY_BAD;
          end else begin
            wtrail_nxt = FIELD_W'(LEFT_W'(VALUE_W) - lsum);
            phase_nxt  = PH_PAY;
          end
        end
      end
      PH_PAY, PH_PAY_BAD: begin
        acc_nxt  = acc_sh;
        left_nxt = left_dec;
        if (left_dec == '0) begin
          prev_nxt = prev_r ^ (acc_sh << sh);
          acc_nxt  = '0;
          emit     = 1'b1;
          emit_bad = (phase_r == PH_PAY_BAD);
        end
      end
      PH_DONE: begin
        emit = 1'b0;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
    if (emit) begin
      phase_nxt = emit_done ? PH_DONE : PH_CTRL1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
      prev_r   <= '0;
      acc_r    <= '0;
      wlead_r  <= '0;
      wtrail_r <= '0;
      plead_r  <= '0;
      left_r   <= '0;
      vdone_r  <= '0;
      phase_r  <= PH_FIRST;
      shreg_r  <= '0;
      drain_r  <= 1'b0;
      bcnt_r   <= '0;
      rcnt_r   <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vcount_r <= cfg_ext[COUNT_WIDTH-1:0];
      end

      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && out_ready) begin
        out_v_r <= 1'b0;
      end

      if (cmd.load) begin
        drain_r <= (in_data.req_type == REQ_DRAIN);
        shreg_r <= (in_data.req_type == REQ_DRAIN) ? '0 : in_data.data_byte;
        bcnt_r  <= '0;
        rcnt_r  <= '0;
        if (in_data.block_start) begin
          prev_r   <= '0;
          acc_r    <= '0;
          wlead_r  <= '0;
          wtrail_r <= '0;
          plead_r  <= '0;
          left_r   <= '0;
          vdone_r  <= '0;
          phase_r  <= PH_FIRST;
        end
      end

      if (cmd.step) begin
        shreg_r <= {shreg_r[BYTE_W-2:0], 1'b0};
        bcnt_r  <= bcnt_r + 1'b1;
      end

      if (do_step) begin
        prev_r   <= prev_nxt;
        acc_r    <= acc_nxt;
        wlead_r  <= wlead_nxt;
        wtrail_r <= wtrail_nxt;
        plead_r  <= plead_nxt;
        left_r   <= left_nxt;
        phase_r  <= phase_nxt;
        if (emit) begin
          vdone_r           <= vdone_inc;
          rcnt_r            <= rcnt_r + 1'b1;
          pend_r.value_bits <= prev_nxt;
          pend_r.block_done <= emit_done;
          pend_r.malformed  <= emit_bad;
          pend_r.last       <= 1'b0;
          pend_v_r          <= 1'b1;
          // earlier result of this transfer is not the last one
          if (pend_v_r) begin
            out_r <= pend_r;
          end
        end
      end

      if (cmd.flush && pend_v_r) begin
        out_r    <= '{pend_r.value_bits, pend_r.block_done, pend_r.malformed, 1'b1};
        pend_v_r <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/xor_float_stream_decoder.sv -----
// XOR float stream decoder: takes a compressed block one byte per transfer,
// msb first, and returns the decoded 64-bit double bit patterns. The stream
// is decoded one bit per clock cycle, while no held-back result stalls, by
// a single shared bit decoder: a data byte passes through accept, one step
// per bit, end of bits and release of its final result, and a drain transfer
// likewise feeds zero bits until the block finishes or 64 results have come out.
// A result waits in a holding register until the next result or the end of
// its transfer marks whether it is the last, then moves to the output
// register; a stalled output holds the bit decoder once a result is held
// back. value_count must be written while no transfer is in progress.
module xor_float_stream_decoder #(
  parameter int COUNT_WIDTH = xfsd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [xfsd_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  xfsd_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output xfsd_pkg::out_t             out_data
);
  import xfsd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  xfsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  xfsd_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ----- sim/xfsd_value_checker.sv -----
module xfsd_value_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [xfsd_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  xfsd_pkg::in_t              in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  xfsd_pkg::out_t             out_data,
  output int                         fail_count,
  output int                         waiting
);
  import xfsd_pkg::*;

  typedef enum logic [2:0] {
    RAW64, CODE_A, CODE_B, LEAD, LEN, PAYLOAD, PAYLOAD_BAD, BLOCK_END
  } phase_t;

  logic [CFG_W-1:0]   count_reg;
  logic [CFG_W-1:0]   done_cnt;
  logic [VALUE_W-1:0] prev_val;
  logic [VALUE_W-1:0] acc;
  logic [FIELD_W-1:0] lead_w;
  logic [FIELD_W-1:0] trail_w;
  logic [FIELD_W-1:0] lead_new;
  logic [LEFT_W-1:0]  left;
  phase_t             phase;
  out_t               batch [MAX_RESULTS];
  int                 batch_n;
  out_t               value_q [$];

  function automatic logic block_over();
    return phase == BLOCK_END || done_cnt >= count_reg;
  endfunction

  task automatic clear_decoder();
    prev_val = '0;
    lead_w   = '0;
    trail_w  = '0;
    done_cnt = '0;
    phase    = RAW64;
    acc      = '0;
    left     = '0;
    lead_new = '0;
  endtask

  task automatic push_value(input logic bad);
    out_t r;
    done_cnt     = done_cnt + 1'b1;
    r.value_bits = prev_val;
    r.block_done = done_cnt >= count_reg;
    r.malformed  = bad;
    r.last       = 1'b0;
    batch[batch_n] = r;
    batch_n++;
    phase = r.block_done ? BLOCK_END : CODE_A;
  endtask

  task automatic feed_bit(input logic b);
    logic [LEFT_W-1:0] len;
    logic              bad;
    if (!block_over()) begin
      case (phase)
        RAW64: begin
          if (left == '0) begin
            left = 7'd64;
            acc  = '0;
          end
          acc  = {acc[VALUE_W-2:0], b};
          left = left - 1'b1;
          if (left == '0) begin
            prev_val = acc;
            acc      = '0;
            push_value(1'b0);
          end
        end
        CODE_A: begin
          if (!b) push_value(1'b0);
          else phase = CODE_B;
        end
        CODE_B: begin
          acc  = '0;
          left = 7'd6;
          if (!b) begin
            phase = LEAD;
          end else begin
            left  = 7'd64 - {1'b0, lead_w} - {1'b0, trail_w};
            phase = PAYLOAD;
          end
        end
        LEAD: begin
          acc  = {acc[VALUE_W-2:0], b};
          left = left - 1'b1;
          if (left == '0) begin
            lead_new = acc[FIELD_W-1:0];
            acc      = '0;
            left     = 7'd6;
            phase    = LEN;
          end
        end
        LEN: begin
          acc  = {acc[VALUE_W-2:0], b};
          left = left - 1'b1;
          if (left == '0) begin
            len    = (acc[FIELD_W-1:0] == '0) ? 7'd64 : {1'b0, acc[FIELD_W-1:0]};
            lead_w = lead_new;
            acc    = '0;
            left   = len;
            if ({2'b0, lead_new} + {1'b0, len} > 8'd64) begin
              trail_w = '0;
              phase   = PAYLOAD_BAD;
            end else begin
              trail_w = 6'(7'd64 - {1'b0, lead_new} - len);
              phase   = PAYLOAD;
            end
          end
        end
        PAYLOAD, PAYLOAD_BAD: begin
          acc = {acc[VALUE_W-2:0], b};
          if (left != '0) left = left - 1'b1;
          if (left == '0) begin
            bad      = phase == PAYLOAD_BAD;
            prev_val = prev_val ^ (bad ? acc : (acc << trail_w));
            acc      = '0;
            push_value(bad);
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic decode_item(input in_t it);
    batch_n = 0;
    if (it.block_start) clear_decoder();
    if (it.req_type == REQ_DATA) begin
      for (int k = BYTE_W - 1; k >= 0; k--) feed_bit(it.data_byte[k]);
    end else begin
      while (!block_over() && batch_n < MAX_RESULTS) feed_bit(1'b0);
    end
    if (batch_n > 0) batch[batch_n-1].last = 1'b1;
    for (int k = 0; k < batch_n; k++) value_q.push_back(batch[k]);
  endtask

  task automatic check_value(input out_t got);
    out_t want;
    if (value_q.size() == 0) begin
      fail_count++;
      $error("result transfer with nothing expected: value_bits %h", got.value_bits);
    end else begin
      want = value_q.pop_front();
      if (got.value_bits !== want.value_bits) begin
        fail_count++;
        $error("value_bits: expected %h, got %h", want.value_bits, got.value_bits);
      end
      if (got.block_done !== want.block_done) begin
        fail_count++;
        $error("block_done: expected %b, got %b", want.block_done, got.block_done);
      end
      if (got.malformed !== want.malformed) begin
        fail_count++;
        $error("malformed: expected %b, got %b", want.malformed, got.malformed);
      end
      if (got.last !== want.last) begin
        fail_count++;
        $error("last: expected %b, got %b", want.last, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      count_reg  = '0;
      fail_count = 0;
      clear_decoder();
      value_q.delete();
    end else begin
      if (out_valid && out_ready) check_value(out_data);
      if (cfg_wr_en) count_reg = cfg_wr_data;
      if (in_valid && in_ready) decode_item(in_data);
    end
    waiting = value_q.size();
  end

endmodule

// ----- sim/xor_float_stream_decoder_test.sv -----
module xor_float_stream_decoder_test;
  import xfsd_pkg::*;

  localparam int ITEM_TARGET = 400;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 32;
  localparam logic [CFG_W-1:0] COUNT_MAX = '1;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;

  int fail_count;
  int waiting;
  int cycles = 0;
  int items_sent = 0;
  int in_calm = 0;
  int out_calm = 0;
  int enc_lead = 0;
  int enc_trail = 0;
  bit stream_q [$];

  xor_float_stream_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  xfsd_value_checker value_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .waiting     (waiting)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // random gaps, with the odd calm stretch of back-to-back transfers
  task automatic draw_gap(inout int calm, output int gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if ($urandom_range(0, 31) == 0) begin
      calm = $urandom_range(10, 40);
      gap  = 0;
    end else begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
    end
  endtask

  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      draw_gap(out_calm, gap);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input logic req, input logic [BYTE_W-1:0] b, input logic bstart);
    int  gap;
    in_t item;
    item.req_type    = req;
    item.data_byte   = b;
    item.block_start = bstart;
    draw_gap(in_calm, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_drain(input logic bstart);
    send_item(REQ_DRAIN, BYTE_W'($urandom), bstart);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic put_bits(input logic [VALUE_W-1:0] v, input int w);
    for (int i = w - 1; i >= 0; i--) stream_q.push_back(v[i]);
  endtask

  task automatic put_raw(input logic [VALUE_W-1:0] v);
    enc_lead  = 0;
    enc_trail = 0;
    put_bits(v, 64);
  endtask

  task automatic put_new_window(input int lead, input int len, input logic [VALUE_W-1:0] pay);
    put_bits(64'b10, 2);
    put_bits(VALUE_W'(lead), 6);
    put_bits(VALUE_W'(len & 63), 6);
    put_bits(pay, len);
    enc_lead  = lead;
    enc_trail = (lead + len > 64) ? 0 : 64 - lead - len;
  endtask

  task automatic put_same_window(input logic [VALUE_W-1:0] pay);
    put_bits(64'b11, 2);
    put_bits(pay, 64 - enc_lead - enc_trail);
  endtask

  task automatic put_random_value();
    int pick;
    int lead;
    int len;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      stream_q.push_back(1'b0);
    end else if (pick < 6) begin
      lead = $urandom_range(0, 63);
      if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 64);
      else len = $urandom_range(1, (64 - lead < 20) ? 64 - lead : 20);
      put_new_window(lead, len, {$urandom, $urandom});
    end else begin
      put_same_window({$urandom, $urandom});
    end
  endtask

  // bytes are packed msb first; a short final byte is padded with random bits
  task automatic send_stream(input logic bstart, input int max_bytes);
    logic [BYTE_W-1:0] b;
    logic              first;
    int                nb;
    first = bstart;
    nb    = 0;
    while (stream_q.size() > 0 && nb < max_bytes) begin
      for (int i = BYTE_W - 1; i >= 0; i--)
        b[i] = (stream_q.size() > 0) ? stream_q.pop_front() : 1'($urandom_range(0, 1));
      send_item(REQ_DATA, b, first);
      first = 1'b0;
      nb++;
    end
  endtask

  initial begin
    int n;
    int pick;
    int mode;
    int half;
    logic [VALUE_W-1:0] raw;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero count: nothing decoded
    write_count('0);
    send_item(REQ_DATA, 8'hA5, 1'b1);
    send_drain(1'b0);

    // repeat, overlong window, reused window, edge window, 64-bit length fed by drain
    settle();
    write_count(CFG_W'(6));
    put_raw('1);
    stream_q.push_back(1'b0);
    put_new_window(40, 40, {$urandom, $urandom});
    put_same_window({$urandom, $urandom});
    put_new_window(63, 1, '1);
    put_bits(64'b10, 2);
    put_bits(64'd0, 12);
    send_stream(1'b1, 1000);
    send_drain(1'b0);

    // finished block ignores bytes even after the count is raised
    settle();
    write_count(CFG_W'(8));
    send_item(REQ_DATA, 8'hFF, 1'b0);

    // largest count: drains stop at the per-transfer result limit
    settle();
    write_count(COUNT_MAX);
    send_item(REQ_DATA, 8'h00, 1'b1);
    send_drain(1'b0);
    send_drain(1'b0);

    while (items_sent < ITEM_TARGET) begin
      settle();
      n    = $urandom_range(1, 10);
      pick = $urandom_range(0, 19);
      if (pick == 0) write_count('0);
      else if (pick == 1) write_count(COUNT_MAX);
      else if (pick < 14) write_count(CFG_W'(n));

      pick = $urandom_range(0, 7);
      raw  = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
      stream_q.delete();
      put_raw(raw);
      repeat (n - 1) put_random_value();

      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        repeat ($urandom_range(1, 24)) if (stream_q.size() > 0) void'(stream_q.pop_back());
        send_stream(1'b1, 1000);
        send_drain(1'b0);
      end else if (mode == 2) begin
        half = (stream_q.size() + 7) / 16;
        send_stream(1'b1, half);
        settle();
        write_count(CFG_W'($urandom_range(0, n + 2)));
        send_stream(half == 0, 1000);
      end else begin
        send_stream(1'b1, 1000);
      end

      if ($urandom_range(0, 3) == 0) send_drain(1'b0);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4))
          send_item(1'($urandom_range(0, 1)), BYTE_W'($urandom), $urandom_range(0, 3) == 0);
      end
    end

    settle();
    if (fail_count == 0 && waiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
